FILE: sv/srrip_pkg.sv
// shared types and constants for the srrip victim selection block
`default_nettype none
package srrip_pkg;

   localparam int SETS     = 1024;
   localparam int WAYS     = 8;
   localparam int SET_BITS = $clog2(SETS);
   localparam int WORD_W   = 2 * WAYS;
   // internal victim index, at least as wide as the reported way field
   localparam int VICTIM_W = (WAYS > 8) ? $clog2(WAYS) : 3;

   localparam logic [1:0] RRPV_MAX    = 2'd3;
   localparam logic [1:0] RRPV_INSERT = 2'd2;
   localparam logic [1:0] RRPV_HIT    = 2'd0;

   typedef logic [SET_BITS-1:0] set_addr_type;
   typedef logic [WORD_W-1:0]   rrpv_word_type;

   localparam rrpv_word_type RRPV_FULL = {WAYS{RRPV_MAX}};

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE
   } ctrl_state_type;

   typedef struct packed {
      rrpv_word_type word;
      logic          write;
      logic [2:0]    victim_way;
      logic          victim_valid;
   } upd_result_type;

endpackage
`default_nettype wire

FILE: sv/srrip_rrpv_mem.sv
// rrpv store: one word per set, one write and one registered read port
`default_nettype none
module srrip_rrpv_mem (
   input  wire logic                   clock,
   input  wire logic                   rd_en,
   input  wire srrip_pkg::set_addr_type  rd_addr,
   output      srrip_pkg::rrpv_word_type rd_data,
   input  wire logic                   wr_en,
   input  wire srrip_pkg::set_addr_type  wr_addr,
   input  wire srrip_pkg::rrpv_word_type wr_data
);
   import srrip_pkg::*;

   rrpv_word_type mem [SETS];
   rrpv_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: sv/srrip_update.sv
// modify step: hit promotion, miss aging and victim pick on one set word
`default_nettype none
module srrip_update (
   input  wire srrip_pkg::rrpv_word_type word,
   input  wire logic [2:0]             way,
   input  wire logic                   hit,
   output      srrip_pkg::upd_result_type result
);
   import srrip_pkg::*;

   always_comb begin
      logic [1:0]          maxv;
      logic [1:0]          age;
      logic [1:0]          v;
      logic                found;
      logic [VICTIM_W-1:0] victim;
      rrpv_word_type       aged;
      rrpv_word_type       hit_word;

      maxv     = '0;
      found    = 1'b0;
      victim   = '0;
      aged     = word;
      hit_word = word;

      // largest value in the set
      for (int w = 0; w < WAYS; w++) begin
         if (word[2*w +: 2] > maxv) begin
            maxv = word[2*w +: 2];
         end
      end
      age = RRPV_MAX - maxv;

      // age every way, lowest way at max is the victim
      for (int w = 0; w < WAYS; w++) begin
         v = word[2*w +: 2] + age;
         aged[2*w +: 2] = v;
         if (!found && v == RRPV_MAX) begin
            found  = 1'b1;
            victim = VICTIM_W'(w);
         end
      end
      for (int w = 0; w < WAYS; w++) begin
         if (found && int'(victim) == w) begin
            aged[2*w +: 2] = RRPV_INSERT;
         end
      end

      // hit way beyond the set leaves the word unchanged
      for (int w = 0; w < WAYS; w++) begin
         if (int'(way) == w) begin
            hit_word[2*w +: 2] = RRPV_HIT;
         end
      end

      if (hit) begin
         result.word         = hit_word;
         result.write        = (int'(way) < WAYS);
         result.victim_way   = '0;
         result.victim_valid = 1'b0;
      end else begin
         result.word         = aged;
         result.write        = 1'b1;
         // only the low bits of the way number are reported
         result.victim_way   = victim[2:0];
         result.victim_valid = 1'b1;
      end
   end

endmodule
`default_nettype wire

FILE: sv/srrip_victim_selection.sv
// srrip victim selection top level: control, clearing pass and response register
// the result strobe is high in the cycle after the update cycle
// a new request is taken only after the read then write-back of the current set word, busy is high meanwhile
// reset: a clearing pass writes every rrpv of all SETS (1024) sets to 3, busy stays high meanwhile
// the result is shown for one cycle only, the receiver cannot stall
`default_nettype none
module srrip_victim_selection (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output      logic       busy,
   input  wire logic [9:0] req_set_index,
   input  wire logic [2:0] req_way,
   input  wire logic       req_hit,
   output      logic       rsp_strobe,
   output      logic [2:0] rsp_victim_way,
   output      logic       rsp_victim_valid
);
   import srrip_pkg::*;

   ctrl_state_type state_ff, state_in;
   set_addr_type   clr_addr_ff, clr_addr_in;

   // captured request beat
   set_addr_type   set_ff;
   logic [2:0]     way_ff;
   logic           hit_ff;

   // response register
   logic           rsp_strobe_ff, rsp_strobe_in;
   logic [2:0]     rsp_way_ff;
   logic           rsp_valid_ff;

   logic           accept;
   set_addr_type   req_addr;
   rrpv_word_type  rd_word;
   upd_result_type upd;

   logic           mem_wr_en;
   set_addr_type   mem_wr_addr;
   rrpv_word_type  mem_wr_data;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start && !busy;
   // set index wraps modulo SETS
   assign req_addr = req_set_index[SET_BITS-1:0];

   srrip_rrpv_mem u_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (req_addr),
      .rd_data (rd_word),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   srrip_update u_update (
      .word   (rd_word),
      .way    (way_ff),
      .hit    (hit_ff),
      .result (upd)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_addr_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_addr_ff   <= clr_addr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         set_ff <= req_addr;
         way_ff <= req_way;
         hit_ff <= req_hit;
      end
      if (state_ff == ST_UPDATE) begin
         rsp_way_ff   <= upd.victim_way;
         rsp_valid_ff <= upd.victim_valid;
      end
   end

   always_comb begin
      state_in      = state_ff;
      clr_addr_in   = clr_addr_ff;
      rsp_strobe_in = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = set_ff;
      mem_wr_data   = upd.word;
      case (state_ff)
         ST_CLEAR: begin
            // sweep one set per cycle with all ways at max
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_addr_ff;
            mem_wr_data = RRPV_FULL;
            clr_addr_in = clr_addr_ff + 1'b1;
            if (clr_addr_ff == set_addr_type'(SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // read data is back, write the modified word and send the result
            mem_wr_en     = upd.write;
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_victim_way   = rsp_way_ff;
   assign rsp_victim_valid = rsp_valid_ff;

   // every accepted beat goes straight to the update cycle
   a_accept_update: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_UPDATE))
      else $error("accepted beat did not enter update");

   // a result only follows an update cycle
   a_strobe_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff == ST_UPDATE))
      else $error("result strobe without update");

   // hit results carry way zero
   a_hit_way_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_victim_valid) |-> (rsp_victim_way == 3'd0))
      else $error("hit result with nonzero way");

   // no request is taken while the store is being cleared
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> (busy && mem_wr_en))
      else $error("clearing pass not holding off requests");

endmodule
`default_nettype wire
